FILE: sv/acms_pkg.sv
// acms_pkg: shared types, constants and helpers for the adaptive cancel mode selector
// depends on nothing; used by adaptive_cancel_mode_selector and its test bench
package acms_pkg;

    localparam int WINDOW_DEPTH = 16;
    localparam int OBJECT_COUNT = 64;

    localparam int OPCODE_W   = 2;
    localparam int OBJ_ID_W   = 6;
    localparam int MISS_W     = 6;
    localparam int THR_W      = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam int OBJ_AW  = (OBJECT_COUNT > 1) ? $clog2(OBJECT_COUNT) : 1;
    localparam int FILL_W  = $clog2(WINDOW_DEPTH);
    localparam int TOTAL_W = $clog2(WINDOW_DEPTH + (1 << MISS_W));
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > THR_W) ? CNT_W : THR_W;

    localparam int CHUNK_W     = 4;
    localparam int PC_W        = 3;
    localparam int NUM_CHUNKS  = (WINDOW_DEPTH + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = NUM_CHUNKS * CHUNK_W;
    localparam int CHUNK_IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;

    localparam logic [OPCODE_W-1:0] OP_CHECK = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_FLUSH = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_PURGE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_THIRD_ENABLE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERM_BELOW    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LAZY_EXIT     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LAZY_ENTER    = 2'd3;

    localparam logic [THR_W-1:0] PERM_BELOW_RST = 5'd4;
    localparam logic [THR_W-1:0] LAZY_EXIT_RST  = 5'd8;
    localparam logic [THR_W-1:0] LAZY_ENTER_RST = 5'd12;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [OBJ_ID_W-1:0] object_id;
        logic                queue_nonempty;
        logic                hit;
        logic [MISS_W-1:0]   miss_count;
    } t_in;

    typedef struct packed {
        logic suppress;
        logic lazy_mode;
        logic permanent;
        logic evaluated;
        logic cancel_lazy_queue;
        logic drop_lazy_queue;
    } t_res;

    typedef struct packed {
        logic [WINDOW_DEPTH-1:0] window;
        logic [FILL_W-1:0]       fill;
        logic                    mode_lazy;
        logic                    permanent;
    } t_entry;

    function automatic logic [PC_W-1:0] chunk_ones(input logic [CHUNK_W-1:0] c);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < CHUNK_W; i++) begin
            n = n + PC_W'(c[i]);
        end
        return n;
    endfunction

endpackage

FILE: sv/acms_ram.sv
// acms_ram: generic single write port, single read port ram with registered read
// depends on nothing
module acms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/adaptive_cancel_mode_selector.sv
// adaptive_cancel_mode_selector: per-object lazy/aggressive cancellation mode tracking
// depends on acms_pkg and acms_ram
//
// channel   handshake                  word
// input     start / busy               i_in (acms_pkg::t_in)
// result    o_res_valid (1-cycle)      o_res (acms_pkg::t_res)
// config    i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// a recorded word that fills the window goes through ram read, window update,
// 4 popcount steps of 4 bits on the shared adder, and decide before the next accept.
// any other word skips the popcount.
// reset is synchronous; mode, permanent mark, window and fill read as zero until written.
// the result strobe lasts one cycle and cannot be stalled; config is always ready.
module adaptive_cancel_mode_selector (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  acms_pkg::t_in                       i_in,
    output logic                                o_res_valid,
    output acms_pkg::t_res                      o_res,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [acms_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [acms_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_CALC = 2'd1;
    localparam logic [1:0] S_CNT  = 2'd2;
    localparam logic [1:0] S_EVAL = 2'd3;

    localparam int D = acms_pkg::WINDOW_DEPTH;

    logic [1:0] r_state;
    logic [1:0] n_state;

    logic                            r_third_en;
    logic [acms_pkg::THR_W-1:0]      r_perm_thr;
    logic [acms_pkg::THR_W-1:0]      r_exit_thr;
    logic [acms_pkg::THR_W-1:0]      r_enter_thr;

    logic [acms_pkg::OBJECT_COUNT-1:0] r_win_vld;
    logic [acms_pkg::OBJECT_COUNT-1:0] r_st_vld;

    acms_pkg::t_in                   r_in;
    logic [D-1:0]                    r_win;
    logic [acms_pkg::PAD_W-1:0]      r_shift;
    logic [acms_pkg::FILL_W-1:0]     r_fill_new;
    logic                            r_full;
    logic                            r_rec;
    logic                            r_inr;
    logic                            r_mode;
    logic                            r_perm;
    logic                            r_supp;
    logic [acms_pkg::CNT_W-1:0]      r_cnt;
    logic [acms_pkg::CHUNK_IDX_W-1:0] r_cidx;
    logic                            r_res_valid;
    acms_pkg::t_res                  r_res;

    logic                            accept;
    logic [acms_pkg::OBJ_AW-1:0]     rd_addr;
    logic [acms_pkg::OBJ_AW-1:0]     obj_addr;
    logic [$bits(acms_pkg::t_entry)-1:0] ram_rdata;
    acms_pkg::t_entry                ent;
    acms_pkg::t_entry                wr_ent;
    logic                            ram_we;

    logic                            in_range;
    logic                            wv;
    logic                            sv_ok;
    logic [D-1:0]                    old_win;
    logic [acms_pkg::FILL_W-1:0]     old_fill;
    logic                            mode_old;
    logic                            perm_old;
    logic                            is_check;
    logic                            is_flush;
    logic                            rec;
    logic                            hbit;
    logic [D-1:0]                    hit_pos;
    logic [acms_pkg::FILL_W:0]       rot_sum;
    logic [acms_pkg::FILL_W-1:0]     rot;
    logic [D-1:0]                    clr_base;
    logic [2*D-1:0]                  clr_wide;
    logic [D-1:0]                    clr;
    logic [D-1:0]                    new_win;
    logic [acms_pkg::TOTAL_W-1:0]    total;
    logic                            full;

    logic [acms_pkg::CMP_W-1:0]      cnt_c;
    logic                            evald;
    logic                            n_mode;
    logic                            n_perm;
    logic                            to_aggr;
    logic                            to_lazy;

    assign accept      = start && !busy;
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    assign obj_addr = acms_pkg::OBJ_AW'(r_in.object_id);
    assign rd_addr  = acms_pkg::OBJ_AW'(i_in.object_id);

    acms_ram #(
        .WIDTH ($bits(acms_pkg::t_entry)),
        .DEPTH (acms_pkg::OBJECT_COUNT)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (obj_addr),
        .i_wdata (wr_ent),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // window update
    always_comb begin
        ent      = acms_pkg::t_entry'(ram_rdata);
        in_range = (32'(r_in.object_id) < 32'(acms_pkg::OBJECT_COUNT));
        wv       = r_win_vld[obj_addr];
        sv_ok    = r_st_vld[obj_addr];
        old_win  = wv ? ent.window : '0;
        old_fill = wv ? ent.fill : '0;
        mode_old = sv_ok && ent.mode_lazy;
        perm_old = sv_ok && ent.permanent;
        is_check = (r_in.opcode == acms_pkg::OP_CHECK);
        is_flush = (r_in.opcode == acms_pkg::OP_FLUSH);
        rec      = in_range && (is_flush || (is_check && r_in.queue_nonempty && !perm_old));
        hbit     = is_check && r_in.hit;
        hit_pos  = D'(1) << old_fill;
        rot_sum  = {1'b0, old_fill} + (acms_pkg::FILL_W + 1)'(hbit);
        if (rot_sum >= (acms_pkg::FILL_W + 1)'(D)) begin
            rot = acms_pkg::FILL_W'(rot_sum - (acms_pkg::FILL_W + 1)'(D));
        end else begin
            rot = acms_pkg::FILL_W'(rot_sum);
        end
        // all ones once the misses cover the whole window
        clr_base = ~({D{1'b1}} << r_in.miss_count);
        clr_wide = {{D{1'b0}}, clr_base} << rot;
        clr      = clr_wide[D-1:0] | clr_wide[2*D-1:D];
        new_win  = (old_win | (hbit ? hit_pos : '0)) & ~clr;
        total    = acms_pkg::TOTAL_W'(old_fill) + acms_pkg::TOTAL_W'(hbit)
                 + acms_pkg::TOTAL_W'(r_in.miss_count);
        full     = (total >= acms_pkg::TOTAL_W'(D));
    end

    // mode decision
    always_comb begin
        cnt_c   = acms_pkg::CMP_W'(r_cnt);
        evald   = r_rec && r_full;
        n_mode  = r_mode;
        n_perm  = r_perm;
        to_aggr = 1'b0;
        to_lazy = 1'b0;
        if (evald) begin
            if (r_third_en && (cnt_c < acms_pkg::CMP_W'(r_perm_thr))) begin
                to_aggr = r_mode;
                n_mode  = 1'b0;
                n_perm  = 1'b1;
            end else if (r_mode && (cnt_c < acms_pkg::CMP_W'(r_exit_thr))) begin
                to_aggr = 1'b1;
                n_mode  = 1'b0;
            end else if (!r_mode && (cnt_c > acms_pkg::CMP_W'(r_enter_thr))) begin
                to_lazy = 1'b1;
                n_mode  = 1'b1;
            end
        end
        ram_we           = (r_state == S_EVAL) && r_rec;
        wr_ent.window    = r_win;
        wr_ent.fill      = r_fill_new;
        wr_ent.mode_lazy = n_mode;
        wr_ent.permanent = n_perm;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_CALC;
                end
            end
            S_CALC: begin
                n_state = (rec && full) ? S_CNT : S_EVAL;
            end
            S_CNT: begin
                if (r_cidx == '0) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_third_en  <= 1'b0;
            r_perm_thr  <= acms_pkg::PERM_BELOW_RST;
            r_exit_thr  <= acms_pkg::LAZY_EXIT_RST;
            r_enter_thr <= acms_pkg::LAZY_ENTER_RST;
            r_win_vld   <= '0;
            r_st_vld    <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_res_valid <= (r_state == S_EVAL);
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    acms_pkg::REG_THIRD_ENABLE: r_third_en  <= i_cfg_data[0];
                    acms_pkg::REG_PERM_BELOW:   r_perm_thr  <= i_cfg_data;
                    acms_pkg::REG_LAZY_EXIT:    r_exit_thr  <= i_cfg_data;
                    acms_pkg::REG_LAZY_ENTER:   r_enter_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            // purge drops every window at once
            if (accept && (i_in.opcode == acms_pkg::OP_PURGE)) begin
                r_win_vld <= '0;
            end
            if (ram_we) begin
                r_win_vld[obj_addr] <= 1'b1;
                r_st_vld[obj_addr]  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in <= i_in;
        end
        if (r_state == S_CALC) begin
            r_win      <= new_win;
            r_shift    <= acms_pkg::PAD_W'(new_win);
            r_fill_new <= full ? '0 : acms_pkg::FILL_W'(total);
            r_full     <= full;
            r_rec      <= rec;
            r_inr      <= in_range;
            r_mode     <= mode_old;
            r_perm     <= perm_old;
            r_supp     <= is_check && rec && mode_old && r_in.hit;
            r_cnt      <= '0;
            r_cidx     <= acms_pkg::CHUNK_IDX_W'(acms_pkg::NUM_CHUNKS - 1);
        end
        if (r_state == S_CNT) begin
            r_cnt   <= r_cnt + acms_pkg::CNT_W'(
                           acms_pkg::chunk_ones(r_shift[acms_pkg::CHUNK_W-1:0]));
            r_shift <= r_shift >> acms_pkg::CHUNK_W;
            r_cidx  <= r_cidx - acms_pkg::CHUNK_IDX_W'(1);
        end
        if (r_state == S_EVAL) begin
            if (r_inr) begin
                r_res.suppress          <= r_supp;
                r_res.lazy_mode         <= n_mode;
                r_res.permanent         <= n_perm;
                r_res.evaluated         <= evald;
                r_res.cancel_lazy_queue <= to_aggr;
                r_res.drop_lazy_queue   <= to_lazy;
            end else begin
                r_res <= '0;
            end
        end
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !busy)
        else $error("result strobe while busy");

    a_cnt_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CNT) |=> (r_state == S_CNT) || (r_state == S_EVAL))
        else $error("popcount left early");

    a_switch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> !(o_res.cancel_lazy_queue && o_res.drop_lazy_queue))
        else $error("both switch flags set");

    a_switch_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.cancel_lazy_queue || o_res.drop_lazy_queue))
        |-> o_res.evaluated)
        else $error("mode switch without evaluation");

    a_supp_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.suppress) |-> (o_res.lazy_mode || o_res.cancel_lazy_queue))
        else $error("suppress on an object that was not lazy");

endmodule

FILE: verif/adaptive_cancel_mode_selector_test.sv
// self-checking bench for adaptive_cancel_mode_selector: directed then phased random words
// holds its own per-object mode predictor in a small scoreboard class; needs acms_pkg
`timescale 1ns / 100ps

module adaptive_cancel_mode_selector_test;

    localparam logic [acms_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int NUM_STAGES = 7;
    localparam int WORDS_PER_STAGE = 250;

    class mode_tracker;
        bit                              lazy [acms_pkg::OBJECT_COUNT];
        bit                              locked [acms_pkg::OBJECT_COUNT];
        bit [acms_pkg::WINDOW_DEPTH-1:0] outcomes [acms_pkg::OBJECT_COUNT];
        bit [6:0]                        fill [acms_pkg::OBJECT_COUNT];
        bit                              third_en;
        bit [acms_pkg::THR_W-1:0]        perm_below;
        bit [acms_pkg::THR_W-1:0]        exit_below;
        bit [acms_pkg::THR_W-1:0]        enter_above;
        acms_pkg::t_res                  expected_modes [$];
        int                              errors;

        function new();
            third_en = 1'b0;
            perm_below = acms_pkg::PERM_BELOW_RST;
            exit_below = acms_pkg::LAZY_EXIT_RST;
            enter_above = acms_pkg::LAZY_ENTER_RST;
            errors = 0;
            for (int i = 0; i < acms_pkg::OBJECT_COUNT; i++) begin
                lazy[i] = 1'b0;
                locked[i] = 1'b0;
                outcomes[i] = '0;
                fill[i] = '0;
            end
        endfunction

        function void set_reg(logic [acms_pkg::CFG_IDX_W-1:0] idx,
                              logic [acms_pkg::CFG_DATA_W-1:0] val);
            case (idx)
                acms_pkg::REG_THIRD_ENABLE: third_en = val[0];
                acms_pkg::REG_PERM_BELOW:   perm_below = val;
                acms_pkg::REG_LAZY_EXIT:    exit_below = val;
                acms_pkg::REG_LAZY_ENTER:   enter_above = val;
                default: ;
            endcase
        endfunction

        function void record(int obj, bit v);
            outcomes[obj][fill[obj] % acms_pkg::WINDOW_DEPTH] = v;
            fill[obj] = fill[obj] + 7'd1;
        endfunction

        function void reevaluate(int obj, inout acms_pkg::t_res r);
            int hits;
            if (fill[obj] < acms_pkg::WINDOW_DEPTH) return;
            hits = $countones(outcomes[obj]);
            if (third_en && hits < int'(perm_below)) begin
                r.cancel_lazy_queue = lazy[obj];
                lazy[obj] = 1'b0;
                locked[obj] = 1'b1;
            end else if (lazy[obj] && hits < int'(exit_below)) begin
                lazy[obj] = 1'b0;
                r.cancel_lazy_queue = 1'b1;
            end else if (!lazy[obj] && hits > int'(enter_above)) begin
                lazy[obj] = 1'b1;
                r.drop_lazy_queue = 1'b1;
            end
            fill[obj] = '0;
            r.evaluated = 1'b1;
        endfunction

        function void note_word(acms_pkg::t_in w);
            acms_pkg::t_res r;
            int obj;
            r = '0;
            obj = int'(w.object_id);
            if (w.opcode == acms_pkg::OP_PURGE) begin
                for (int i = 0; i < acms_pkg::OBJECT_COUNT; i++) begin
                    outcomes[i] = '0;
                    fill[i] = '0;
                end
            end
            if (w.opcode == acms_pkg::OP_CHECK) begin
                if (w.queue_nonempty && !locked[obj]) begin
                    r.suppress = lazy[obj] && w.hit;
                    if (w.hit) record(obj, 1'b1);
                    repeat (w.miss_count) record(obj, 1'b0);
                    reevaluate(obj, r);
                end
            end else if (w.opcode == acms_pkg::OP_FLUSH) begin
                repeat (w.miss_count) record(obj, 1'b0);
                reevaluate(obj, r);
            end
            r.lazy_mode = lazy[obj];
            r.permanent = locked[obj];
            expected_modes = {expected_modes, r};
        endfunction

        task report(string msg);
            $display("%0t ns: mismatch: %s", $time, msg);
            errors++;
        endtask

        task compare_bit(string field, logic got, logic want);
            if (got !== want) report($sformatf("%s got %b expected %b", field, got, want));
        endtask

        task check_word(acms_pkg::t_res got);
            acms_pkg::t_res want;
            if (expected_modes.size() == 0) begin
                report("result word with no word pending");
                return;
            end
            want = expected_modes.pop_front();
            compare_bit("suppress", got.suppress, want.suppress);
            compare_bit("lazy_mode", got.lazy_mode, want.lazy_mode);
            compare_bit("permanent", got.permanent, want.permanent);
            compare_bit("evaluated", got.evaluated, want.evaluated);
            compare_bit("cancel_lazy_queue", got.cancel_lazy_queue, want.cancel_lazy_queue);
            compare_bit("drop_lazy_queue", got.drop_lazy_queue, want.drop_lazy_queue);
        endtask

        task check_drained();
            if (expected_modes.size() != 0)
                report($sformatf("%0d result words never arrived", expected_modes.size()));
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             start;
    logic                             busy;
    acms_pkg::t_in                    i_in;
    logic                             o_res_valid;
    acms_pkg::t_res                   o_res;
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [acms_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [acms_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    mode_tracker board = new();
    bit calm;

    adaptive_cancel_mode_selector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_res_valid === 1'b1) board.check_word(o_res);
    end

    function automatic acms_pkg::t_in make_word(logic [acms_pkg::OPCODE_W-1:0] op, int obj,
                                                bit qne, bit hit, int misses);
        acms_pkg::t_in w;
        w.opcode = op;
        w.object_id = acms_pkg::OBJ_ID_W'(obj);
        w.queue_nonempty = qne;
        w.hit = hit;
        w.miss_count = acms_pkg::MISS_W'(misses);
        return w;
    endfunction

    function automatic acms_pkg::t_in pick_word(int hot_base, int hit_pct);
        acms_pkg::t_in w;
        int roll;
        int mroll;
        roll = $urandom_range(99);
        mroll = $urandom_range(99);
        w.opcode = (roll < 80) ? acms_pkg::OP_CHECK : (roll < 98) ? acms_pkg::OP_FLUSH :
                   (roll < 99) ? acms_pkg::OP_PURGE : OP_UNUSED;
        w.object_id = acms_pkg::OBJ_ID_W'(($urandom_range(99) < 80)
                          ? hot_base + $urandom_range(3)
                          : $urandom_range(acms_pkg::OBJECT_COUNT - 1));
        w.queue_nonempty = ($urandom_range(99) < 90);
        w.hit = ($urandom_range(99) < hit_pct);
        w.miss_count = acms_pkg::MISS_W'((mroll < 55) ? 0
                           : (mroll < 88) ? $urandom_range(3, 1) : $urandom_range(63));
        return w;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_word(acms_pkg::t_in w);
        while (!calm && $urandom_range(99) < 29) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start = 1'b1;
        i_in = w;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_word(w);
        @(negedge i_clk);
    endtask

    task automatic settle(int extra);
        int guard;
        start = 1'b0;
        guard = 0;
        while (board.expected_modes.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (extra) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic apply_thresholds(bit te, int pb, int lx, int le);
        logic [acms_pkg::CFG_DATA_W-1:0] vals [4];
        vals[0] = acms_pkg::CFG_DATA_W'(te);
        vals[1] = acms_pkg::CFG_DATA_W'(pb);
        vals[2] = acms_pkg::CFG_DATA_W'(lx);
        vals[3] = acms_pkg::CFG_DATA_W'(le);
        for (int i = 0; i < 4; i++) begin
            i_cfg_valid = 1'b1;
            i_cfg_index = acms_pkg::CFG_IDX_W'(i);
            i_cfg_data = vals[i];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            board.set_reg(i_cfg_index, i_cfg_data);
            @(negedge i_clk);
        end
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_directed();
        send_word(make_word(acms_pkg::OP_CHECK, 0, 1'b0, 1'b1, 63));
        send_word(make_word(acms_pkg::OP_CHECK, 63, 1'b1, 1'b1, 0));
        send_word(make_word(acms_pkg::OP_FLUSH, 63, 1'b0, 1'b0, 63));
        repeat (13) send_word(make_word(acms_pkg::OP_CHECK, 1, 1'b1, 1'b1, 0));
        send_word(make_word(acms_pkg::OP_CHECK, 1, 1'b1, 1'b1, 2));
        send_word(make_word(acms_pkg::OP_CHECK, 1, 1'b1, 1'b1, 0));
        send_word(make_word(acms_pkg::OP_FLUSH, 1, 1'b1, 1'b0, 15));
        send_word(make_word(acms_pkg::OP_PURGE, 1, 1'b1, 1'b1, 5));
        send_word(make_word(OP_UNUSED, 1, 1'b0, 1'b1, 7));
        send_word(make_word(acms_pkg::OP_FLUSH, 2, 1'b0, 1'b1, 16));
    endtask

    initial begin
        int hit_pct;
        int hot_base;
        start = 1'b0;
        i_in = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        calm = 1'b0;
        i_rst_n = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        run_directed();

        for (int stage = 0; stage < NUM_STAGES; stage++) begin
            settle(10);
            case (stage)
                0: ;
                1: apply_thresholds(1'b0, 0, 16, 0);
                2: apply_thresholds(1'b1, 0, 0, 16);
                3: apply_thresholds(1'b1, 16, 8, 8);
                default: apply_thresholds(bit'($urandom_range(1)), $urandom_range(16),
                                          $urandom_range(16), $urandom_range(16));
            endcase
            calm = (stage == 1);
            hot_base = (stage * 8) % acms_pkg::OBJECT_COUNT;
            hit_pct = 50;
            for (int n = 0; n < WORDS_PER_STAGE; n++) begin
                if (n % 32 == 0) hit_pct = $urandom_range(100);
                send_word(pick_word(hot_base, hit_pct));
            end
        end

        settle(12);
        board.check_drained();
        if (board.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/acms_pkg.sv
sv/acms_ram.sv
sv/adaptive_cancel_mode_selector.sv
verif/adaptive_cancel_mode_selector_test.sv
